FILE: src/sensor_frame_crc_temperature_decode_defines.svh
// Assertion macros for the sensor frame decoder RTL.
`ifndef SENSOR_FRAME_CRC_TEMPERATURE_DECODE_DEFINES_SVH
`define SENSOR_FRAME_CRC_TEMPERATURE_DECODE_DEFINES_SVH
`ifndef SYNTHESIS
`define SFCTD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor frame decoder: same-cycle check failed");
`define SFCTD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sensor frame decoder: next-cycle check failed");
`else
`define SFCTD_ASSERT_IMP(label, ante, cons)
`define SFCTD_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: src/sfctd_pkg.sv
// Types, constants and the CRC-8 function of the sensor frame decoder.
package sfctd_pkg;

  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned POS_W = 3;

  localparam logic [POS_W-1:0] POS_STATUS   = 3'd0;
  localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd3;
  localparam logic [POS_W-1:0] POS_TEMP_MID = 3'd4;
  localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd5;
  localparam logic [POS_W-1:0] POS_CHECK    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_LAST     = 3'd7;

  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;
  localparam int unsigned RAW_W = 20;
  localparam int unsigned PROD_W = RAW_W + 15;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic               crc_ok;
    logic               busy_res;
  } out_item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

FILE: src/sensor_frame_crc_temperature_decode.sv
// Sensor frame decoder top level: CRC-8 check and temperature conversion.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data (rx_byte, frame_start)
//   out     | output    | out_valid / out_ready | out_data (temp_centi, crc_ok, busy_res)
//
// Each byte is captured in an input register and processed from there.
// One byte per cycle is sustained; the check byte's result goes out
// through the result register. Only a check byte waiting on a full, stalled
// result register holds up the input. Reset is synchronous and active low.
`include "sensor_frame_crc_temperature_decode_defines.svh"

module sensor_frame_crc_temperature_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfctd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfctd_pkg::out_item_t out_data
);
  import sfctd_pkg::*;

  logic              in_vld_r;
  in_item_t          in_data_r;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt;
  logic [7:0]        status_r, status_nxt;

  logic [POS_W-1:0]  pos;
  logic              is_check;
  logic              adv;
  logic [PROD_W-1:0] product;
  logic [14:0]       scaled;

  always_comb begin
    pos = in_data_r.frame_start ? POS_STATUS : byte_pos_r;
    is_check = pos inside {[POS_CHECK:POS_LAST]};
    adv = in_vld_r && (!is_check || !out_vld_r || out_ready);
  end

  assign in_ready = !in_vld_r || adv;

  always_comb begin
    product = PROD_W'(raw_r) * PROD_W'(TEMP_SCALE);
    scaled = product[PROD_W-1:RAW_W];
  end

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    crc_nxt = crc_r;
    raw_nxt = raw_r;
    status_nxt = status_r;
    if (adv) begin
      if (is_check) begin
        byte_pos_nxt = POS_STATUS;
        crc_nxt = CRC_INIT;
      end else begin
        byte_pos_nxt = pos + 1'b1;
        if (pos == POS_STATUS) begin
          crc_nxt = crc8_byte(CRC_INIT, in_data_r.rx_byte);
          status_nxt = in_data_r.rx_byte;
        end else begin
          crc_nxt = crc8_byte(crc_r, in_data_r.rx_byte);
        end
        case (pos)
          POS_TEMP_HI: begin
            raw_nxt = {in_data_r.rx_byte[3:0], 16'h0000};
          end
          POS_TEMP_MID: begin
            raw_nxt = {raw_r[19:16], in_data_r.rx_byte, raw_r[7:0]};
          end
          POS_TEMP_LO: begin
            raw_nxt = {raw_r[19:8], in_data_r.rx_byte};
          end
          default: begin
            raw_nxt = raw_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    out_data_nxt = out_data_r;
    if (adv && is_check) begin
      out_vld_nxt = 1'b1;
      out_data_nxt.temp_centi = $signed(scaled - TEMP_OFFSET);
      out_data_nxt.crc_ok = (crc_r == in_data_r.rx_byte);
      out_data_nxt.busy_res = status_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      byte_pos_r <= POS_STATUS;
      crc_r <= CRC_INIT;
      raw_r <= '0;
      status_r <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      byte_pos_r <= byte_pos_nxt;
      crc_r <= crc_nxt;
      raw_r <= raw_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data = out_data_r;

  `SFCTD_ASSERT_IMP(a_pos_in_frame, 1'b1, byte_pos_r != POS_LAST)
  `SFCTD_ASSERT_IMP(a_no_overwrite, in_vld_r && is_check && out_vld_r && !out_ready, !adv)
  `SFCTD_ASSERT_NXT(a_result_loaded, adv && is_check, out_vld_r)
  `SFCTD_ASSERT_NXT(a_frame_restart, adv && is_check, byte_pos_r == POS_STATUS && crc_r == CRC_INIT)

endmodule

FILE: dv/sfctd_frame_checker.sv
// Scoreboard for the sensor frame decoder: result prediction and field comparison.
package sensor_frame_tb_pkg;

  localparam int unsigned FRAME_LEN = 7;
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_RAW_HI = 3'd3;
  localparam logic [2:0] POS_RAW_MID = 3'd4;
  localparam logic [2:0] POS_RAW_LO = 3'd5;
  localparam logic [2:0] POS_CHECK_BYTE = 3'(FRAME_LEN - 1);
  localparam logic [7:0] CRC_SEED = 8'hFF;
  localparam logic [7:0] GEN_POLY = 8'h31;
  localparam logic [34:0] TEMP_GAIN = 35'd20000;
  localparam logic [14:0] TEMP_BIAS = 15'd5000;

  // Bit-serial form of the CRC-8 update, MSB of the data byte first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      if (r[7] ^ data[i]) begin
        r = {r[6:0], 1'b0} ^ GEN_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

module sfctd_frame_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  sfctd_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  sfctd_pkg::out_item_t out_data,
  output int unsigned          fail_count,
  output int unsigned          results_due
);
  import sensor_frame_tb_pkg::*;

  logic [2:0]           pos;
  logic [7:0]           crc_run;
  logic [19:0]          raw_t;
  logic [7:0]           status_q;
  sfctd_pkg::out_item_t decoded_q[$];

  function automatic void decode_byte(input sfctd_pkg::in_item_t it);
    logic [2:0]           p;
    logic [34:0]          prod;
    sfctd_pkg::out_item_t r;
    p = it.frame_start ? POS_FIRST : pos;
    if (p >= POS_CHECK_BYTE) begin
      prod = {15'd0, raw_t} * TEMP_GAIN;
      r.temp_centi = prod[34:20] - TEMP_BIAS;
      r.crc_ok = (crc_run == it.rx_byte);
      r.busy_res = status_q[7];
      decoded_q.push_back(r);
      pos = POS_FIRST;
      crc_run = CRC_SEED;
    end else begin
      if (p == POS_FIRST) begin
        crc_run = crc8_update(CRC_SEED, it.rx_byte);
        status_q = it.rx_byte;
      end else begin
        crc_run = crc8_update(crc_run, it.rx_byte);
      end
      case (p)
        POS_RAW_HI: begin
          raw_t = {it.rx_byte[3:0], 16'h0000};
        end
        POS_RAW_MID: begin
          raw_t[15:8] = it.rx_byte;
        end
        POS_RAW_LO: begin
          raw_t[7:0] = it.rx_byte;
        end
        default: begin
        end
      endcase
      pos = p + 3'd1;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    int unsigned          bad;
    sfctd_pkg::out_item_t want;
    bad = 0;
    if (!rst_n) begin
      pos = POS_FIRST;
      crc_run = CRC_SEED;
      raw_t = '0;
      status_q = '0;
      decoded_q.delete();
      fail_count <= 0;
      results_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result item: temp_centi=%0d crc_ok=%0b busy_res=%0b",
                 out_data.temp_centi, out_data.crc_ok, out_data.busy_res);
          bad++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.temp_centi !== want.temp_centi) begin
            $error("temp_centi expected %0d actual %0d", want.temp_centi, out_data.temp_centi);
            bad++;
          end
          if (out_data.crc_ok !== want.crc_ok) begin
            $error("crc_ok expected %0b actual %0b", want.crc_ok, out_data.crc_ok);
            bad++;
          end
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res expected %0b actual %0b", want.busy_res, out_data.busy_res);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data);
      end
      fail_count <= fail_count + bad;
      results_due <= decoded_q.size();
    end
  end

endmodule

FILE: dv/tb_sensor_frame_crc_temperature_decode.sv
// Testbench top for the sensor frame decoder: stimulus, handshake idling and verdict.
module tb_sensor_frame_crc_temperature_decode;
  import sensor_frame_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sfctd_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sfctd_pkg::out_item_t out_data;
  int unsigned          fail_count;
  int unsigned          results_due;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;
  int unsigned          sent = 0;

  always #1 clk = ~clk;

  sensor_frame_crc_temperature_decode i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sfctd_frame_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.rx_byte <= b;
    in_data.frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_frame(input logic [47:0] body, input logic fs0, input logic good_crc);
    logic [7:0] crc;
    logic [7:0] b;
    crc = CRC_SEED;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      b = body[47 - 8 * i -: 8];
      crc = crc8_update(crc, b);
      send_byte(b, (i == 0) ? fs0 : 1'b0);
    end
    send_byte(good_crc ? crc : crc ^ 8'($urandom_range(1, 255)), 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned     frame_no;
    int unsigned     pick;
    int unsigned     n;
    int unsigned     base;
    bit              aligned;
    logic [47:0]     body;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_frame(48'h80_00_00_F0_00_00, 1'b1, 1'b1);
    send_frame(48'h7F_FF_FF_0F_FF_FF, 1'b0, 1'b0);
    send_byte(8'h1C, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_frame(48'h1C_12_34_08_00_00, 1'b1, 1'b1);

    base = sent;
    frame_no = 0;
    aligned = 1'b1;
    while (sent - base < RANDOM_ITEMS) begin
      quiet = (frame_no >= 40 && frame_no < 52) || (frame_no >= 90 && frame_no < 110);
      if (frame_no == 40) begin
        hold_req = 1'b1;
      end
      if (frame_no == 60) begin
        drain_results();
      end
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        body = {$urandom(), 16'($urandom())};
        if (pick == 0) begin
          body[23:0] = 24'h0F_FF_FF;
        end else if (pick == 1) begin
          body[23:0] = 24'hF0_00_00;
        end
        send_frame(body, aligned ? 1'($urandom_range(0, 1)) : 1'b1, $urandom_range(0, 3) != 0);
        aligned = 1'b1;
      end else if (pick < 18) begin
        n = $urandom_range(1, FRAME_LEN - 1);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom()), i == 0);
        end
        aligned = 1'b0;
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
        end
        aligned = 1'b0;
      end
      frame_no++;
    end

    quiet = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 3);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
